// File: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the polygon plane splitter core.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int MAX_VERTS = 32;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = $clog2(MAX_VERTS);
   localparam int CNT_W     = $clog2(MAX_VERTS + 1);
   localparam int ID_W      = 24;
   localparam int CRD_W     = 32;
   localparam int CLS_W     = 2;
   localparam int MUL_W     = CRD_W + 1;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DIST_W    = 2 * CRD_W - FRAC_BITS + 5;
   localparam int REM_W     = DIST_W + 1;
   localparam int T_W       = FRAC_BITS + 1;
   localparam int STEP_W    = $clog2(FRAC_BITS);

   localparam logic [CLS_W-1:0] CLS_IN   = 2'd0;
   localparam logic [CLS_W-1:0] CLS_OUT  = 2'd1;
   localparam logic [CLS_W-1:0] CLS_ON   = 2'd2;
   localparam logic [CLS_W-1:0] CLS_RSVD = 2'd3;
   localparam logic [CLS_W-1:0] SIDE_BOTH = 2'd2;

   localparam logic [1:0] REG_NX  = 2'd0;
   localparam logic [1:0] REG_NY  = 2'd1;
   localparam logic [1:0] REG_NZ  = 2'd2;
   localparam logic [1:0] REG_OFF = 2'd3;

   localparam int ENTRY_W = ID_W + 3 * CRD_W + CLS_W;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] z;
      logic [CLS_W-1:0]        cls;
   } entry_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RD_PREV,
      ST_WAIT_PREV,
      ST_RD,
      ST_CHECK,
      ST_DMUL,
      ST_DACC,
      ST_DSETUP,
      ST_DIV,
      ST_LMUL,
      ST_LACC,
      ST_EMIT_NEW,
      ST_EMIT_VTX
   } state_type;

endpackage

// File: rtl/core/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/polygon_plane_splitter_core.sv
// ----------------------------------------------------------------------------
// polygon_plane_splitter_core
// Splits one polygon by a plane into an in loop and an out loop.
// ----------------------------------------------------------------------------
// Usage: program the plane normal and offset through the csr_ write channel
// while the block is idle. Then send the polygon on the req_ channel, one
// vertex per transfer, with req_last_vertex on the final one. Vertices past
// the store depth are dropped and reported by rsp_overflow.
// Non-final vertices are taken without a stall. After the final vertex,
// req_stall stays high while the core walks the stored loop: it reads the
// last stored vertex as the start of the first edge, then reads each vertex
// in turn and sends it as a plain result. An edge that crosses the plane
// first yields its intersection point: the shared multiplier forms the two
// plane distances, a setup step prepares the division, sixteen divider
// steps give t (skipped when t clamps to zero or one), the multiplier
// interpolates the point, and it is sent before the vertex. rsp_last_result
// marks the final result of a polygon. When the receiver stalls, the
// current result holds and the walk waits. Reset empties the vertex store
// count, clears overflow and plane registers and returns to accepting input.
// ----------------------------------------------------------------------------
module polygon_plane_splitter_core
   import pps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ID_W-1:0]          req_vertex_id,
   input  logic signed [CRD_W-1:0]  req_point_x,
   input  logic signed [CRD_W-1:0]  req_point_y,
   input  logic signed [CRD_W-1:0]  req_point_z,
   input  logic [CLS_W-1:0]         req_vertex_class,
   input  logic                     req_last_vertex,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_loop_side,
   output logic                     rsp_is_new,
   output logic [ID_W-1:0]          rsp_result_vertex_id,
   output logic signed [CRD_W-1:0]  rsp_result_x,
   output logic signed [CRD_W-1:0]  rsp_result_y,
   output logic signed [CRD_W-1:0]  rsp_result_z,
   output logic                     rsp_overflow,
   output logic                     rsp_last_result
);

   state_type state_ff, state_in;

   logic signed [CRD_W-1:0]  normal_ff [3];
   logic signed [CRD_W-1:0]  offset_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     ovf_ff;
   logic [CNT_W-1:0]         walk_ff;
   logic [2:0]               k_ff;
   entry_type                a_ff, b_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [DIST_W-1:0] da_ff, db_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [DIST_W-1:0]        den_ff;
   logic [T_W-1:0]           t_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [CRD_W-1:0]  crd_ff [3];

   entry_type                wr_entry, rd_entry;
   logic [ENTRY_W-1:0]       rd_bits;
   logic                     in_xfer, out_xfer, wr_en, rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     span;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [DIST_W-1:0] prod_sh;
   logic signed [CRD_W-1:0]  a_crd [3], b_crd [3];
   logic signed [DIST_W-1:0] num_raw, den_raw, num_abs, den_abs;
   logic [REM_W-1:0]         rem_sh;
   logic                     walk_last;

   assign in_xfer  = req_valid && !req_stall;
   assign out_xfer = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_LOAD);

   // Class three is folded into the on class when the vertex is stored.
   always_comb begin
      wr_entry.id  = req_vertex_id;
      wr_entry.x   = req_point_x;
      wr_entry.y   = req_point_y;
      wr_entry.z   = req_point_z;
      wr_entry.cls = (req_vertex_class == CLS_RSVD) ? CLS_ON : req_vertex_class;
   end

   assign wr_en   = in_xfer && (count_ff < CNT_W'(MAX_VERTS));
   assign rd_en   = (state_ff == ST_RD_PREV) || (state_ff == ST_RD);
   assign rd_addr = (state_ff == ST_RD_PREV) ? IDX_W'(count_ff - 1'b1) : walk_ff[IDX_W-1:0];

   pps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_VERTS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign rd_entry = entry_type'(rd_bits);

   assign span = (rd_entry.cls != CLS_ON) && (a_ff.cls != CLS_ON) && (a_ff.cls != rd_entry.cls);

   assign a_crd[0] = a_ff.x;
   assign a_crd[1] = a_ff.y;
   assign a_crd[2] = a_ff.z;
   assign b_crd[0] = b_ff.x;
   assign b_crd[1] = b_ff.y;
   assign b_crd[2] = b_ff.z;

   // Shared multiplier: plane distance terms first, then interpolation.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_LMUL) begin
         mul_a = MUL_W'(b_crd[k_ff[1:0]]) - MUL_W'(a_crd[k_ff[1:0]]);
         mul_b = MUL_W'(signed'({1'b0, t_ff}));
      end else if (k_ff < 3'd3) begin
         mul_a = MUL_W'(normal_ff[k_ff[1:0]]);
         mul_b = MUL_W'(a_crd[k_ff[1:0]]);
      end else begin
         mul_a = MUL_W'(normal_ff[2'(k_ff - 3'd3)]);
         mul_b = MUL_W'(b_crd[2'(k_ff - 3'd3)]);
      end
   end

   assign prod_sh = DIST_W'(prod_ff >>> FRAC_BITS);

   assign num_raw = da_ff;
   assign den_raw = da_ff - db_ff;
   assign num_abs = den_raw[DIST_W-1] ? -num_raw : num_raw;
   assign den_abs = den_raw[DIST_W-1] ? -den_raw : den_raw;
   assign rem_sh  = {rem_ff[REM_W-2:0], 1'b0};
   assign walk_last = (walk_ff == count_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:      if (in_xfer && req_last_vertex) state_in = ST_RD_PREV;
         ST_RD_PREV:   state_in = ST_WAIT_PREV;
         ST_WAIT_PREV: state_in = ST_RD;
         ST_RD:        state_in = ST_CHECK;
         ST_CHECK:     state_in = span ? ST_DMUL : ST_EMIT_VTX;
         ST_DMUL:      state_in = ST_DACC;
         ST_DACC:      state_in = (k_ff == 3'd5) ? ST_DSETUP : ST_DMUL;
         ST_DSETUP: begin
            if (den_abs == '0 || num_abs <= 0 || num_abs >= den_abs) state_in = ST_LMUL;
            else state_in = ST_DIV;
         end
         ST_DIV:       if (step_ff == STEP_W'(FRAC_BITS - 1)) state_in = ST_LMUL;
         ST_LMUL:      state_in = ST_LACC;
         ST_LACC:      state_in = (k_ff == 3'd2) ? ST_EMIT_NEW : ST_LMUL;
         ST_EMIT_NEW:  if (out_xfer) state_in = ST_EMIT_VTX;
         ST_EMIT_VTX: begin
            if (out_xfer) state_in = walk_last ? ST_LOAD : ST_RD;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         normal_ff <= '{default: '0};
         offset_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_NX:  normal_ff[0] <= csr_data;
               REG_NY:  normal_ff[1] <= csr_data;
               REG_NZ:  normal_ff[2] <= csr_data;
               REG_OFF: offset_ff    <= csr_data;
            endcase
         end
         if (wr_en) begin
            count_ff <= count_ff + 1'b1;
         end else if (in_xfer) begin
            ovf_ff <= 1'b1;
         end
         if (state_ff == ST_EMIT_VTX && out_xfer && walk_last) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_RD_PREV:   walk_ff <= '0;
         ST_WAIT_PREV: a_ff <= rd_entry;
         ST_CHECK: begin
            b_ff  <= rd_entry;
            k_ff  <= '0;
            da_ff <= DIST_W'(offset_ff);
            db_ff <= DIST_W'(offset_ff);
         end
         ST_DMUL, ST_LMUL: prod_ff <= mul_a * mul_b;
         ST_DACC: begin
            if (k_ff < 3'd3) da_ff <= da_ff + prod_sh;
            else db_ff <= db_ff + prod_sh;
            k_ff <= (k_ff == 3'd5) ? 3'd0 : k_ff + 1'b1;
         end
         ST_DSETUP: begin
            step_ff <= '0;
            rem_ff  <= REM_W'(num_abs);
            den_ff  <= den_abs;
            if (den_abs == '0 || num_abs <= 0) t_ff <= '0;
            else if (num_abs >= den_abs) t_ff <= T_W'(1) << FRAC_BITS;
            else t_ff <= '0;
         end
         ST_DIV: begin
            step_ff <= step_ff + 1'b1;
            if (rem_sh >= REM_W'(den_ff)) begin
               rem_ff <= rem_sh - REM_W'(den_ff);
               t_ff   <= {t_ff[T_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               t_ff   <= {t_ff[T_W-2:0], 1'b0};
            end
         end
         ST_LACC: begin
            crd_ff[k_ff[1:0]] <= a_crd[k_ff[1:0]] + prod_sh[CRD_W-1:0];
            k_ff <= (k_ff == 3'd2) ? 3'd0 : k_ff + 1'b1;
         end
         ST_EMIT_VTX: begin
            if (out_xfer) begin
               a_ff    <= b_ff;
               walk_ff <= walk_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid            = (state_ff == ST_EMIT_NEW) || (state_ff == ST_EMIT_VTX);
      rsp_overflow         = ovf_ff;
      if (state_ff == ST_EMIT_NEW) begin
         rsp_loop_side        = SIDE_BOTH;
         rsp_is_new           = 1'b1;
         rsp_result_vertex_id = '0;
         rsp_result_x         = crd_ff[0];
         rsp_result_y         = crd_ff[1];
         rsp_result_z         = crd_ff[2];
         rsp_last_result      = 1'b0;
      end else begin
         rsp_loop_side        = b_ff.cls;
         rsp_is_new           = 1'b0;
         rsp_result_vertex_id = b_ff.id;
         rsp_result_x         = b_ff.x;
         rsp_result_y         = b_ff.y;
         rsp_result_z         = b_ff.z;
         rsp_last_result      = walk_last;
      end
   end

endmodule
